FILE: rtl/core/hbkd_pkg.sv
// ----------------------------------------------------------------------------
// hbkd_pkg: shared types, constants and usage table
// Constants, event types and the HID usage to keycode map used by the
// boot keyboard diff unit.
// ----------------------------------------------------------------------------
package hbkd_pkg;

   localparam int KEY_SLOTS      = 6;
   localparam int SLOT_CAP       = 6;
   localparam int MOD_BITS       = 8;
   localparam int NUM_EVENTS     = MOD_BITS + 2 * KEY_SLOTS;

   localparam logic [7:0] USAGE_IGNORE_MAX = 8'h03;
   localparam logic [7:0] MOD_USAGE_BASE   = 8'hE0;
   localparam logic [7:0] KEYCODE_NONE     = 8'd0;

   typedef logic [7:0] usage_type;
   typedef usage_type [KEY_SLOTS-1:0] key_array_type;

   // one candidate event
   typedef struct packed {
      logic      valid;
      logic      down;
      usage_type code;
   } event_type;

   typedef event_type [NUM_EVENTS-1:0] event_vec_type;

   // hid usage to input keycode, zero where no mapping exists
   function automatic usage_type usage_map(input usage_type usage);
      usage_type code;
      case (usage)
         8'h04: code = 8'd30;  8'h05: code = 8'd48;  8'h06: code = 8'd46;
         8'h07: code = 8'd32;  8'h08: code = 8'd18;  8'h09: code = 8'd33;
         8'h0A: code = 8'd34;  8'h0B: code = 8'd35;  8'h0C: code = 8'd23;
         8'h0D: code = 8'd36;  8'h0E: code = 8'd37;  8'h0F: code = 8'd38;
         8'h10: code = 8'd50;  8'h11: code = 8'd49;  8'h12: code = 8'd24;
         8'h13: code = 8'd25;  8'h14: code = 8'd16;  8'h15: code = 8'd19;
         8'h16: code = 8'd31;  8'h17: code = 8'd20;  8'h18: code = 8'd22;
         8'h19: code = 8'd47;  8'h1A: code = 8'd17;  8'h1B: code = 8'd45;
         8'h1C: code = 8'd21;  8'h1D: code = 8'd44;
         8'h1E: code = 8'd2;   8'h1F: code = 8'd3;   8'h20: code = 8'd4;
         8'h21: code = 8'd5;   8'h22: code = 8'd6;   8'h23: code = 8'd7;
         8'h24: code = 8'd8;   8'h25: code = 8'd9;   8'h26: code = 8'd10;
         8'h27: code = 8'd11;  8'h28: code = 8'd28;  8'h29: code = 8'd1;
         8'h2A: code = 8'd14;  8'h2B: code = 8'd15;  8'h2C: code = 8'd57;
         8'h2D: code = 8'd12;  8'h2E: code = 8'd13;  8'h2F: code = 8'd26;
         8'h30: code = 8'd27;  8'h31: code = 8'd43;  8'h32: code = 8'd86;
         8'h33: code = 8'd39;  8'h34: code = 8'd40;  8'h35: code = 8'd41;
         8'h36: code = 8'd51;  8'h37: code = 8'd52;  8'h38: code = 8'd53;
         8'h39: code = 8'd58;  8'h3A: code = 8'd59;  8'h3B: code = 8'd60;
         8'h3C: code = 8'd61;  8'h3D: code = 8'd62;  8'h3E: code = 8'd63;
         8'h3F: code = 8'd64;  8'h40: code = 8'd65;  8'h41: code = 8'd66;
         8'h42: code = 8'd67;  8'h43: code = 8'd68;  8'h44: code = 8'd87;
         8'h45: code = 8'd88;  8'h46: code = 8'd99;  8'h47: code = 8'd70;
         8'h48: code = 8'd119; 8'h49: code = 8'd110; 8'h4A: code = 8'd102;
         8'h4B: code = 8'd104; 8'h4C: code = 8'd111; 8'h4D: code = 8'd107;
         8'h4E: code = 8'd109; 8'h4F: code = 8'd106; 8'h50: code = 8'd105;
         8'h51: code = 8'd108; 8'h52: code = 8'd103; 8'h53: code = 8'd69;
         8'h54: code = 8'd98;  8'h55: code = 8'd55;  8'h56: code = 8'd74;
         8'h57: code = 8'd78;  8'h58: code = 8'd96;  8'h59: code = 8'd79;
         8'h5A: code = 8'd80;  8'h5B: code = 8'd81;  8'h5C: code = 8'd75;
         8'h5D: code = 8'd76;  8'h5E: code = 8'd77;  8'h5F: code = 8'd71;
         8'h60: code = 8'd72;  8'h61: code = 8'd73;  8'h62: code = 8'd82;
         8'h63: code = 8'd83;  8'h65: code = 8'd139;
         8'hE0: code = 8'd29;  8'hE1: code = 8'd42;  8'hE2: code = 8'd56;
         8'hE3: code = 8'd125; 8'hE4: code = 8'd97;  8'hE5: code = 8'd54;
         8'hE6: code = 8'd100; 8'hE7: code = 8'd126;
         default: code = KEYCODE_NONE;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/core/hbkd_if.sv
// ----------------------------------------------------------------------------
// hbkd_if: channel interfaces
// Valid/ready channels for reports, key events and the enable register.
// ----------------------------------------------------------------------------

// keyboard report channel
interface hbkd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifier_bits;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;
   logic       report_short;

   modport source (output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                   key_slot_3, key_slot_4, key_slot_5, report_short, input ready);
   modport sink   (input valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                   key_slot_3, key_slot_4, key_slot_5, report_short, output ready);
endinterface

// key event channel
interface hbkd_rsp_if;
   logic       valid;
   logic       ready;
   logic       key_down;
   logic [7:0] keycode;
   logic       last_event;

   modport source (output valid, key_down, keycode, last_event, input ready);
   modport sink   (input valid, key_down, keycode, last_event, output ready);
endinterface

// enable register write channel
interface hbkd_csr_if;
   logic valid;
   logic ready;
   logic keyboard_enabled;

   modport source (output valid, keyboard_enabled, input ready);
   modport sink   (input valid, keyboard_enabled, output ready);
endinterface

FILE: rtl/core/hid_boot_keyboard_diff_unit.sv
// ----------------------------------------------------------------------------
// hid_boot_keyboard_diff_unit: boot keyboard report to key events
// The first event is offered in the cycle after its report is accepted, then
// one per cycle while the sink is ready; a report holds the unit until its
// final event (at most 20) is taken, and the next report is taken in that cycle.
// A report with no events leaves the unit free. The serializer sets the rate.
// Reset clears the stored report and enables the keyboard.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_diff_unit (
   input  logic       clock,
   input  logic       reset,
   hbkd_req_if.sink   req_bus,
   hbkd_rsp_if.source rsp_bus,
   hbkd_csr_if.sink   csr_bus
);

   localparam int NK = hbkd_pkg::KEY_SLOTS;
   localparam int MB = hbkd_pkg::MOD_BITS;

   hbkd_pkg::key_array_type prev_keys_ff, prev_keys_in;
   logic [7:0]              prev_mods_ff, prev_mods_in;
   logic                    enabled_ff, enabled_in;
   hbkd_pkg::usage_type     slot_all [hbkd_pkg::SLOT_CAP];
   hbkd_pkg::key_array_type new_keys;
   hbkd_pkg::event_vec_type events;
   hbkd_pkg::event_vec_type load_events;
   logic                    free;
   logic                    req_acc;
   logic                    take;

   // configuration register
   assign csr_bus.ready = 1'b1;
   assign enabled_in    = (csr_bus.valid && csr_bus.ready) ? csr_bus.keyboard_enabled
                                                           : enabled_ff;

   // report fields to slot array
   assign slot_all[0] = req_bus.key_slot_0;
   assign slot_all[1] = req_bus.key_slot_1;
   assign slot_all[2] = req_bus.key_slot_2;
   assign slot_all[3] = req_bus.key_slot_3;
   assign slot_all[4] = req_bus.key_slot_4;
   assign slot_all[5] = req_bus.key_slot_5;

   always_comb begin
      for (int i = 0; i < NK; i++) new_keys[i] = slot_all[i];
   end

   assign req_bus.ready = free;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign take          = req_acc && enabled_ff && !req_bus.report_short;

   // modifier events
   for (genvar b = 0; b < MB; b++) begin : g_mod
      hbkd_pkg::usage_type mod_code;
      assign mod_code  = hbkd_pkg::usage_map(hbkd_pkg::MOD_USAGE_BASE + 8'(b));
      assign events[b] = '{valid: (req_bus.modifier_bits[b] != prev_mods_ff[b]) &&
                                  (mod_code != hbkd_pkg::KEYCODE_NONE),
                           down:  req_bus.modifier_bits[b],
                           code:  mod_code};
   end

   // one lane per key slot
   for (genvar g = 0; g < NK; g++) begin : g_lane
      hbkd_lane u_lane (
         .old_key       (prev_keys_ff[g]),
         .new_key       (new_keys[g]),
         .old_keys      (prev_keys_ff),
         .new_keys      (new_keys),
         .release_event (events[MB + 2 * g]),
         .press_event   (events[MB + 2 * g + 1])
      );
   end

   // dropped reports load an empty queue
   always_comb begin
      load_events = events;
      if (!take) begin
         for (int i = 0; i < hbkd_pkg::NUM_EVENTS; i++) load_events[i].valid = 1'b0;
      end
   end

   hbkd_event_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .load        (req_acc),
      .load_events (load_events),
      .free        (free),
      .rsp_bus     (rsp_bus)
   );

   // stored report
   assign prev_keys_in = take ? new_keys : prev_keys_ff;
   assign prev_mods_in = take ? req_bus.modifier_bits : prev_mods_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
         prev_mods_ff <= '0;
         enabled_ff   <= 1'b1;
      end else begin
         prev_keys_ff <= prev_keys_in;
         prev_mods_ff <= prev_mods_in;
         enabled_ff   <= enabled_in;
      end
   end

   // a dropped report never produces a beat
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !take) |=> !rsp_bus.valid)
      else $error("dropped report produced an event");

   // events continue until the flagged one
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_event) |=> rsp_bus.valid)
      else $error("event stream ended without last flag");

   // stored report only moves on a taken report
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !take) |=> ($stable(prev_keys_ff) && $stable(prev_mods_ff)))
      else $error("stored report changed without a report");

endmodule

FILE: rtl/core/hbkd_lane.sv
// ----------------------------------------------------------------------------
// hbkd_lane: per-slot compare lane
// Finds the release of the old key and the press of the new key in one slot
// and maps both usages to keycodes.
// ----------------------------------------------------------------------------
module hbkd_lane (
   input  hbkd_pkg::usage_type     old_key,
   input  hbkd_pkg::usage_type     new_key,
   input  hbkd_pkg::key_array_type old_keys,
   input  hbkd_pkg::key_array_type new_keys,
   output hbkd_pkg::event_type     release_event,
   output hbkd_pkg::event_type     press_event
);

   logic                old_in_new;
   logic                new_in_old;
   hbkd_pkg::usage_type old_code;
   hbkd_pkg::usage_type new_code;

   // membership search across all slots
   always_comb begin
      old_in_new = 1'b0;
      new_in_old = 1'b0;
      for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++) begin
         if (new_keys[i] == old_key) old_in_new = 1'b1;
         if (old_keys[i] == new_key) new_in_old = 1'b1;
      end
   end

   assign old_code = hbkd_pkg::usage_map(old_key);
   assign new_code = hbkd_pkg::usage_map(new_key);

   // unmapped usages are dropped
   always_comb begin
      release_event.valid = (old_key > hbkd_pkg::USAGE_IGNORE_MAX) && !old_in_new &&
                            (old_code != hbkd_pkg::KEYCODE_NONE);
      release_event.down  = 1'b0;
      release_event.code  = old_code;
      press_event.valid   = (new_key > hbkd_pkg::USAGE_IGNORE_MAX) && !new_in_old &&
                            (new_code != hbkd_pkg::KEYCODE_NONE);
      press_event.down    = 1'b1;
      press_event.code    = new_code;
   end

endmodule

FILE: rtl/core/hbkd_event_queue.sv
// ----------------------------------------------------------------------------
// hbkd_event_queue: event merge and serializer
// Holds the candidate events of one report and sends the pending ones in
// order, one beat per cycle while the sink is ready, flagging the final one.
// ----------------------------------------------------------------------------
module hbkd_event_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  hbkd_pkg::event_vec_type load_events,
   output logic                    free,
   hbkd_rsp_if.source              rsp_bus
);

   localparam int N = hbkd_pkg::NUM_EVENTS;

   logic [N-1:0]        mask_ff, mask_in;
   logic [N-1:0]        down_ff, down_in;
   hbkd_pkg::usage_type code_ff [N];
   hbkd_pkg::usage_type code_in [N];
   logic [N-1:0]        pick;
   logic                pop;
   logic                sel_down;
   hbkd_pkg::usage_type sel_code;

   // lowest pending event goes first
   assign pick = mask_ff & (~mask_ff + {{(N-1){1'b0}}, 1'b1});
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      sel_down = 1'b0;
      sel_code = '0;
      for (int i = 0; i < N; i++) begin
         if (pick[i]) begin
            sel_down = sel_down | down_ff[i];
            sel_code = sel_code | code_ff[i];
         end
      end
   end

   assign rsp_bus.valid      = |mask_ff;
   assign rsp_bus.key_down   = sel_down;
   assign rsp_bus.keycode    = sel_code;
   assign rsp_bus.last_event = ((mask_ff & ~pick) == '0);

   // free once the final beat leaves
   assign free = !rsp_bus.valid || (pop && rsp_bus.last_event);

   // next queue contents
   always_comb begin
      mask_in = mask_ff;
      down_in = down_ff;
      for (int i = 0; i < N; i++) code_in[i] = code_ff[i];
      if (load) begin
         for (int i = 0; i < N; i++) begin
            mask_in[i] = load_events[i].valid;
            down_in[i] = load_events[i].down;
            code_in[i] = load_events[i].code;
         end
      end else if (pop) begin
         mask_in = mask_ff & ~pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      down_ff <= down_in;
      for (int i = 0; i < N; i++) code_ff[i] <= code_in[i];
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: boot keyboard diff unit testbench
// Sends boot keyboard reports, first from a directed table and then at
// random, and checks every key event against an in-bench model of the diff
// logic. Both channels stall at random and the enable register is toggled
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one keyboard report as driven on the request channel
   typedef struct packed {
      logic                    short_rep;
      logic [7:0]              mods;
      hbkd_pkg::key_array_type keys;
   } report_type;

   // one key event as seen on the result channel
   typedef struct packed {
      logic       down;
      logic [7:0] code;
      logic       last;
   } key_event_type;

   // directed row: typed_n < 0 means the model decides the events
   typedef struct {
      report_type    rpt;
      int            typed_n;
      key_event_type ev0;
      key_event_type ev1;
   } step_row_type;

   localparam logic [7:0]    FIRST_KEY_USAGE = 8'h04;
   localparam logic [7:0]    LAST_KEY_USAGE  = 8'h65;
   localparam logic [7:0]    LAST_MOD_USAGE  = 8'hE7;
   localparam int            IDLE_PCT        = 18;
   localparam key_event_type NO_EV           = '0;

   // keycodes for usages 0x04 .. 0x65, zero where unmapped
   localparam logic [0:97][7:0] BASE_CODES = {
      8'd30, 8'd48, 8'd46, 8'd32, 8'd18, 8'd33, 8'd34, 8'd35, 8'd23, 8'd36,
      8'd37, 8'd38, 8'd50, 8'd49, 8'd24, 8'd25, 8'd16, 8'd19, 8'd31, 8'd20,
      8'd22, 8'd47, 8'd17, 8'd45, 8'd21, 8'd44,
      8'd2,  8'd3,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,  8'd10, 8'd11,
      8'd28, 8'd1,  8'd14, 8'd15, 8'd57, 8'd12, 8'd13, 8'd26, 8'd27, 8'd43,
      8'd86, 8'd39, 8'd40, 8'd41, 8'd51, 8'd52, 8'd53, 8'd58,
      8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68,
      8'd87, 8'd88,
      8'd99, 8'd70, 8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109,
      8'd106, 8'd105, 8'd108, 8'd103,
      8'd69, 8'd98, 8'd55, 8'd74, 8'd78, 8'd96, 8'd79, 8'd80, 8'd81, 8'd75,
      8'd76, 8'd77, 8'd71, 8'd72, 8'd73, 8'd82, 8'd83,
      8'd0,  8'd139
   };

   // keycodes for modifier usages 0xE0 .. 0xE7
   localparam logic [0:7][7:0] MOD_CODES = {
      8'd29, 8'd42, 8'd56, 8'd125, 8'd97, 8'd54, 8'd100, 8'd126
   };

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;
   logic calm = 1'b0;
   int   errors = 0;

   // model state
   hbkd_pkg::key_array_type held_keys;
   logic [7:0]              held_mods;
   logic                    kbd_enabled;

   key_event_type fresh_events[$];
   key_event_type pending_events[$];
   step_row_type  script[$];

   hbkd_req_if req_if ();
   hbkd_rsp_if rsp_if ();
   hbkd_csr_if csr_if ();

   assign rsp_if.ready = sink_ready;

   hid_boot_keyboard_diff_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(2_000_000);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [7:0] usage_keycode(input logic [7:0] u);
      if (u >= FIRST_KEY_USAGE && u <= LAST_KEY_USAGE)
         return BASE_CODES[u - FIRST_KEY_USAGE];
      if (u >= hbkd_pkg::MOD_USAGE_BASE && u <= LAST_MOD_USAGE)
         return MOD_CODES[u - hbkd_pkg::MOD_USAGE_BASE];
      return 8'd0;
   endfunction

   // unmapped usages produce no event
   function automatic void note_event(input logic down, input logic [7:0] usage);
      logic [7:0] code;
      code = usage_keycode(usage);
      if (code != 8'd0)
         fresh_events.push_back('{down, code, 1'b0});
   endfunction

   function automatic logic slots_hold(input hbkd_pkg::key_array_type slots,
                                       input logic [7:0] u);
      for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++)
         if (slots[i] == u)
            return 1'b1;
      return 1'b0;
   endfunction

   // diff one report against the held one, events land in fresh_events
   function automatic void diff_report(input report_type r);
      logic [7:0] old_k;
      logic [7:0] new_k;
      fresh_events.delete();
      if (!kbd_enabled || r.short_rep)
         return;
      // modifier changes first
      for (int i = 0; i < 8; i++)
         if (r.mods[i] != held_mods[i])
            note_event(r.mods[i], hbkd_pkg::usage_type'(hbkd_pkg::MOD_USAGE_BASE + i));
      // then per slot: release of old, press of new
      for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++) begin
         old_k = held_keys[i];
         new_k = r.keys[i];
         if (old_k > hbkd_pkg::USAGE_IGNORE_MAX && !slots_hold(r.keys, old_k))
            note_event(1'b0, old_k);
         if (new_k > hbkd_pkg::USAGE_IGNORE_MAX && !slots_hold(held_keys, new_k))
            note_event(1'b1, new_k);
      end
      held_mods = r.mods;
      held_keys = r.keys;
      if (fresh_events.size() > 0)
         fresh_events[fresh_events.size()-1].last = 1'b1;
   endfunction

   function automatic report_type rep(input logic [7:0] m, k0, k1, k2, k3, k4, k5,
                                      input logic s = 1'b0);
      report_type r;
      r.short_rep = s;
      r.mods      = m;
      r.keys[0]   = k0;
      r.keys[1]   = k1;
      r.keys[2]   = k2;
      r.keys[3]   = k3;
      r.keys[4]   = k4;
      r.keys[5]   = k5;
      return r;
   endfunction

   // mostly small edits of the held report, some noise and short reports
   function automatic report_type random_report();
      report_type  r;
      int          pick;
      logic [63:0] noise;
      pick  = $urandom_range(99);
      noise = {$urandom, $urandom};
      r.short_rep = 1'b0;
      if (pick < 6) begin
         r = noise[$bits(report_type)-1:0];
         r.short_rep = 1'b1;
      end else if (pick < 16) begin
         r = noise[$bits(report_type)-1:0];
         r.short_rep = 1'b0;
      end else begin
         case ($urandom_range(3))
            0: r.mods = held_mods;
            1: r.mods = held_mods ^ (8'h01 << $urandom_range(7));
            2: r.mods = held_mods ^ (8'h01 << $urandom_range(7))
                                  ^ (8'h01 << $urandom_range(7));
            default: r.mods = 8'($urandom);
         endcase
         for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++) begin
            pick = $urandom_range(9);
            if (pick < 5)
               r.keys[i] = held_keys[i];
            else if (pick < 7)
               r.keys[i] = 8'h00;
            else
               r.keys[i] = 8'($urandom_range(FIRST_KEY_USAGE, LAST_KEY_USAGE));
         end
      end
      return r;
   endfunction

   // send one report, queue the events it should cause
   task automatic push_report(input report_type r, input int typed_n = -1,
                              input key_event_type t0 = NO_EV,
                              input key_event_type t1 = NO_EV);
      int gap;
      gap = 0;
      if (!calm)
         while ($urandom_range(99) < IDLE_PCT)
            gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.modifier_bits <= r.mods;
      req_if.key_slot_0    <= r.keys[0];
      req_if.key_slot_1    <= r.keys[1];
      req_if.key_slot_2    <= r.keys[2];
      req_if.key_slot_3    <= r.keys[3];
      req_if.key_slot_4    <= r.keys[4];
      req_if.key_slot_5    <= r.keys[5];
      req_if.report_short  <= r.short_rep;
      do @(posedge clock); while (!req_if.ready);
      diff_report(r);
      if (typed_n < 0) begin
         foreach (fresh_events[i])
            pending_events.push_back(fresh_events[i]);
      end else begin
         if (typed_n > 0)
            pending_events.push_back(t0);
         if (typed_n > 1)
            pending_events.push_back(t1);
      end
   endtask

   // enable register write, only once the unit has drained
   task automatic write_enable(input logic v);
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_if.valid            <= 1'b1;
      csr_if.keyboard_enabled <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      kbd_enabled = v;
   endtask

   // result channel: check each beat, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && sink_ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event: expected none, got down=%0b code=%0d last=%0b",
                     $time, rsp_if.key_down, rsp_if.keycode, rsp_if.last_event);
            errors++;
         end else begin
            key_event_type want;
            want = pending_events.pop_front();
            if (rsp_if.key_down !== want.down || rsp_if.keycode !== want.code ||
                rsp_if.last_event !== want.last) begin
               $display("%0t: mismatch: exp down=%0b code=%0d last=%0b got %0b %0d %0b",
                        $time, want.down, want.code, want.last,
                        rsp_if.key_down, rsp_if.keycode, rsp_if.last_event);
               errors++;
            end
         end
      end
      sink_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // stimulus
   initial begin
      reset                   = 1'b1;
      req_if.valid            = 1'b0;
      req_if.modifier_bits    = '0;
      req_if.key_slot_0       = '0;
      req_if.key_slot_1       = '0;
      req_if.key_slot_2       = '0;
      req_if.key_slot_3       = '0;
      req_if.key_slot_4       = '0;
      req_if.key_slot_5       = '0;
      req_if.report_short     = 1'b0;
      csr_if.valid            = 1'b0;
      csr_if.keyboard_enabled = 1'b0;
      held_keys               = '0;
      held_mods               = '0;
      kbd_enabled             = 1'b1;

      // directed table
      // left control press and release from the cleared state
      script.push_back('{rep(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                         '{1'b1, 8'd29, 1'b1}, NO_EV});
      script.push_back('{rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                         '{1'b0, 8'd29, 1'b1}, NO_EV});
      // all modifiers down then up
      script.push_back('{rep(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                         -1, NO_EV, NO_EV});
      script.push_back('{rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                         -1, NO_EV, NO_EV});
      // top modifier bit, then swap it for the first mapped key
      script.push_back('{rep(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                         '{1'b1, 8'd126, 1'b1}, NO_EV});
      script.push_back('{rep(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 2,
                         '{1'b0, 8'd126, 1'b0}, '{1'b1, 8'd30, 1'b1}});
      // last mapped key in the last slot
      script.push_back('{rep(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65), 1,
                         '{1'b1, 8'd139, 1'b1}, NO_EV});
      // all slots full
      script.push_back('{rep(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h65),
                         -1, NO_EV, NO_EV});
      // short report with everything set is dropped
      script.push_back('{rep(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1),
                         0, NO_EV, NO_EV});
      // no change, then the same keys in other slots
      script.push_back('{rep(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h65),
                         0, NO_EV, NO_EV});
      script.push_back('{rep(8'h00, 8'h65, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08),
                         -1, NO_EV, NO_EV});
      // unmapped top usage everywhere: releases only
      script.push_back('{rep(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                         -1, NO_EV, NO_EV});
      // ignored low usages and the unmapped gap usage
      script.push_back('{rep(8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 8'hFF, 8'h64),
                         -1, NO_EV, NO_EV});
      // repeated usage in every slot
      script.push_back('{rep(8'h00, 8'h2C, 8'h2C, 8'h2C, 8'h2C, 8'h2C, 8'h2C),
                         -1, NO_EV, NO_EV});
      script.push_back('{rep(8'h00, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                         -1, NO_EV, NO_EV});
      script.push_back('{rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                         '{1'b0, 8'd57, 1'b1}, NO_EV});
      // largest burst: all modifiers plus six releases and six presses
      script.push_back('{rep(8'h00, 8'h29, 8'h3A, 8'h45, 8'h46, 8'h52, 8'h53),
                         -1, NO_EV, NO_EV});
      script.push_back('{rep(8'hFF, 8'h04, 8'h1E, 8'h28, 8'h39, 8'h47, 8'h63),
                         -1, NO_EV, NO_EV});
      // modifier usages sent as keys
      script.push_back('{rep(8'h55, 8'hE0, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h00),
                         -1, NO_EV, NO_EV});
      // unmapped usages across the range
      script.push_back('{rep(8'h00, 8'h66, 8'hA0, 8'hDF, 8'hE8, 8'hFE, 8'h80),
                         -1, NO_EV, NO_EV});
      script.push_back('{rep(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1),
                         0, NO_EV, NO_EV});
      script.push_back('{rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                         -1, NO_EV, NO_EV});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_enable(1'b1);
      foreach (script[i])
         push_report(script[i].rpt, script[i].typed_n, script[i].ev0, script[i].ev1);

      // disabled keyboard keeps its state
      write_enable(1'b0);
      for (int i = 0; i < 6; i++)
         push_report(random_report());
      write_enable(1'b1);

      // random reports, with a stretch of no stalls
      for (int i = 0; i < 80; i++) begin
         calm = (i >= 30 && i < 70);
         push_report(random_report());
      end
      calm = 1'b0;

      write_enable(1'b0);
      for (int i = 0; i < 8; i++)
         push_report(random_report());
      write_enable(1'b1);

      for (int i = 0; i < 54; i++)
         push_report(random_report());

      // drain
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_events.size() != 0) begin
         $display("%0t: %0d events never arrived", $time, pending_events.size());
         errors++;
      end
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
